@@ design/least_loaded_decoder_dispatch_assert.svh @@
// Assertion shorthands shared by the dispatch logic.
// Each expects i_clk and i_rst_n in scope.
`ifndef LEAST_LOADED_DECODER_DISPATCH_ASSERT_SVH
`define LEAST_LOADED_DECODER_DISPATCH_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LLDD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LLDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/lldd_pkg.sv @@
package lldd_pkg;

    localparam int RATE_W     = 40;
    localparam int TIME_W     = 64;
    localparam int CHUNK_W    = 16;
    localparam int COLUMN_W   = 12;
    localparam int BYTES_W    = 32;
    localparam int VALUES_W   = 32;
    localparam int VSIZE_W    = 5;
    localparam int ID_OUT_W   = 4;
    localparam int CFG_IDX_W  = 8;

    // Input word layout, lowest bit first
    localparam int IN_DATA_W  = 104;
    localparam int IN_USER_W  = 1;
    // Output word layout, lowest bit first
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 3;

    localparam logic [RATE_W-1:0] SETUP_RST      = 40'd33627785747;
    localparam logic [RATE_W-1:0] TRANSFER_RST   = 40'd276955;
    localparam logic [RATE_W-1:0] DECOMPRESS_RST = 40'd46655585492;
    localparam logic [RATE_W-1:0] PLAIN_RST      = 40'd2611778;

    localparam logic [CFG_IDX_W-1:0] CFG_SETUP      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECOMPRESS = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAIN      = 8'd3;

    localparam logic FUNC_SCHEDULE = 1'b0;
    localparam logic FUNC_DEQUEUE  = 1'b1;

    typedef struct packed {
        logic [RATE_W-1:0] setup;
        logic [RATE_W-1:0] transfer;
        logic [RATE_W-1:0] decompress;
        logic [RATE_W-1:0] plain;
    } t_cost_cfg;

    typedef struct packed {
        logic [BYTES_W-1:0]  cbytes;
        logic [VALUES_W-1:0] values;
        logic [VSIZE_W-1:0]  vsize;
        logic                compressed;
    } t_job;

endpackage

@@ design/lldd_ram.sv @@
module lldd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/lldd_cost.sv @@
module lldd_cost (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  lldd_pkg::t_cost_cfg           i_cfg,
    input  lldd_pkg::t_job                i_job,
    output logic                          o_done,
    output logic [lldd_pkg::TIME_W-1:0]   o_cost
);

    import lldd_pkg::*;

    localparam int HALF_W = RATE_W / 2;
    localparam int OPND_W = 38;
    localparam int PROD_W = HALF_W + OPND_W;
    localparam int TERM_W = RATE_W + OPND_W;
    localparam logic [2:0] LAST_MUL_STEP = 3'd5;
    localparam logic [2:0] LAST_STEP     = 3'd7;

    typedef enum logic [1:0] {C_IDLE, C_PREP, C_RUN} t_cstate;

    t_cstate             r_state;
    logic [2:0]          r_step;
    logic                r_done;
    logic [OPND_W-1:0]   r_sum;
    logic [PROD_W-1:0]   r_prod;
    logic [TERM_W-1:0]   r_term;
    logic [TIME_W-1:0]   r_cost;

    logic [RATE_W-1:0]   w_rate;
    logic [HALF_W-1:0]   w_rate_half;
    logic [OPND_W-1:0]   w_opnd;
    logic [PROD_W-1:0]   w_prod;
    logic [TIME_W-1:0]   w_term_sat;
    logic [TIME_W:0]     w_cost_sum;
    logic [OPND_W-2:0]   w_out_bytes;

    // Step pairs 0-1, 2-3, 4-5: low and high rate halves of each term
    always_comb begin
        unique case (r_step[2:1])
            2'd0: begin
                w_rate = i_cfg.transfer;
                w_opnd = r_sum;
            end
            2'd1: begin
                w_rate = i_cfg.decompress;
                w_opnd = OPND_W'(i_job.cbytes);
            end
            default: begin
                w_rate = i_cfg.plain;
                w_opnd = OPND_W'(i_job.values);
            end
        endcase
    end

    assign w_rate_half = r_step[0] ? w_rate[RATE_W-1:HALF_W] : w_rate[HALF_W-1:0];
    assign w_prod      = w_rate_half * w_opnd;
    assign w_out_bytes = i_job.values * i_job.vsize;

    // Drop the decompress term for raw chunks
    always_comb begin
        if (r_step == 3'd5 && !i_job.compressed) begin
            w_term_sat = '0;
        end else if (|r_term[TERM_W-1:TIME_W]) begin
            w_term_sat = '1;
        end else begin
            w_term_sat = r_term[TIME_W-1:0];
        end
    end

    assign w_cost_sum = {1'b0, r_cost} + {1'b0, w_term_sat};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_done  <= 1'b0;
                        r_state <= C_PREP;
                    end
                end
                C_PREP: begin
                    r_sum   <= OPND_W'(i_job.cbytes) + OPND_W'(w_out_bytes);
                    r_cost  <= TIME_W'(i_cfg.setup);
                    r_step  <= '0;
                    r_state <= C_RUN;
                end
                C_RUN: begin
                    if (r_step <= LAST_MUL_STEP) begin
                        r_prod <= w_prod;
                    end
                    if (r_step >= 3'd1 && r_step <= 3'd6) begin
                        if (r_step[0]) begin
                            r_term <= TERM_W'(r_prod);
                        end else begin
                            r_term <= r_term + {r_prod, {HALF_W{1'b0}}};
                        end
                    end
                    if (r_step == 3'd3 || r_step == 3'd5 || r_step == LAST_STEP) begin
                        r_cost <= w_cost_sum[TIME_W] ? '1 : w_cost_sum[TIME_W-1:0];
                    end
                    if (r_step == LAST_STEP) begin
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_cost = r_cost;

endmodule

@@ design/least_loaded_decoder_dispatch.sv @@
// Schedule word: cost estimate runs beside the busy-time scan, which is skipped
//   when the order queue is full; dequeue word skips the read on an empty queue.
// One word at a time; the next word can be taken the cycle after the result
//   enters the output register. Speed is set by six passes of one 20x38 multiplier
//   and by the scan of the busy-time RAM through its single read port.
// Reset: synchronous, active low; clears busy times (valid bits), queue, r_m_valid.
`include "least_loaded_decoder_dispatch_assert.svh"

module least_loaded_decoder_dispatch #(
    parameter int NUM_DECODERS = 16,
    parameter int ORDER_DEPTH  = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // job word in
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // chunk_index, column_index, compressed_bytes, value_count, value_size,
    // is_compressed, zero pad
    input  logic [lldd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // func
    input  logic [lldd_pkg::IN_USER_W-1:0]     s_axis_tuser,
    // result word out
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // decoder number, job_chunk, job_column, job_cost
    output logic [lldd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // result_kind, refused, order_empty
    output logic [lldd_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    // cost register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lldd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lldd_pkg::RATE_W-1:0]        i_cfg_data
);

    import lldd_pkg::*;

    localparam int ID_W  = (NUM_DECODERS > 1) ? $clog2(NUM_DECODERS) : 1;
    localparam int PTR_W = $clog2(ORDER_DEPTH);
    localparam int CNT_W = $clog2(ORDER_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_UPDATE,
        S_DEQ,
        S_OUT
    } t_state;

    t_state                 r_state;
    t_cost_cfg              r_cfg;
    t_job                   r_job;
    logic                   r_func;
    logic [CHUNK_W-1:0]     r_chunk;
    logic [COLUMN_W-1:0]    r_column;

    // least-loaded scan
    logic [ID_W-1:0]        r_scan_addr;
    logic                   r_cmp_vld;
    logic [ID_W-1:0]        r_cmp_idx;
    logic                   r_rd_vld;
    logic [ID_W-1:0]        r_best;
    logic [TIME_W-1:0]      r_best_val;
    logic [NUM_DECODERS-1:0] r_bvalid;

    // order queue
    logic [PTR_W-1:0]       r_head;
    logic [PTR_W-1:0]       r_tail;
    logic [CNT_W-1:0]       r_count;

    // result under construction
    logic [ID_W-1:0]        r_id;
    logic                   r_refused;
    logic                   r_empty;

    // output register
    logic                   r_m_valid;
    logic                   r_m_kind;
    logic                   r_m_refused;
    logic                   r_m_empty;
    logic [ID_OUT_W-1:0]    r_m_id;
    logic [CHUNK_W-1:0]     r_m_chunk;
    logic [COLUMN_W-1:0]    r_m_column;
    logic [TIME_W-1:0]      r_m_cost;

    logic                   w_accept;
    logic                   w_cost_start;
    logic                   w_cost_done;
    logic [TIME_W-1:0]      w_cost;
    logic [TIME_W-1:0]      w_busy_rdata;
    logic [TIME_W-1:0]      w_cand;
    logic [TIME_W:0]        w_busy_sum;
    logic [TIME_W-1:0]      w_busy_new;
    logic                   w_push;
    logic [ID_W-1:0]        w_fifo_rdata;
    logic [ID_W+ID_OUT_W-1:0] w_id_ext;
    logic                   w_full;
    logic                   w_out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_cost_start  = w_accept && (s_axis_tuser[0] == FUNC_SCHEDULE);
    assign w_full        = (r_count == CNT_W'(ORDER_DEPTH));
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // A decoder never written reads as idle since reset
    assign w_cand     = r_rd_vld ? w_busy_rdata : '0;
    assign w_busy_sum = {1'b0, r_best_val} + {1'b0, w_cost};
    assign w_busy_new = w_busy_sum[TIME_W] ? '1 : w_busy_sum[TIME_W-1:0];
    assign w_push     = (r_state == S_UPDATE);
    assign w_id_ext   = {{ID_OUT_W{1'b0}}, r_id};

    lldd_cost u_cost (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cost_start),
        .i_cfg   (r_cfg),
        .i_job   (r_job),
        .o_done  (w_cost_done),
        .o_cost  (w_cost)
    );

    // Busy time per decoder; read by the scan, written once per scheduled job
    lldd_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NUM_DECODERS)
    ) u_busy_ram (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_best),
        .i_wdata (w_busy_new),
        .i_raddr (r_scan_addr),
        .o_rdata (w_busy_rdata)
    );

    // Delivery order of decoder ids
    lldd_ram #(
        .WIDTH (ID_W),
        .DEPTH (ORDER_DEPTH)
    ) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_tail),
        .i_wdata (r_best),
        .i_raddr (r_head),
        .o_rdata (w_fifo_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_cfg.setup     <= SETUP_RST;
            r_cfg.transfer  <= TRANSFER_RST;
            r_cfg.decompress <= DECOMPRESS_RST;
            r_cfg.plain     <= PLAIN_RST;
            r_bvalid        <= '0;
            r_head          <= '0;
            r_tail          <= '0;
            r_count         <= '0;
            r_cmp_vld       <= 1'b0;
            r_m_valid       <= 1'b0;
        end else begin
            // Cost registers: indexes past the list are dropped
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SETUP:      r_cfg.setup      <= i_cfg_data;
                    CFG_TRANSFER:   r_cfg.transfer   <= i_cfg_data;
                    CFG_DECOMPRESS: r_cfg.decompress <= i_cfg_data;
                    CFG_PLAIN:      r_cfg.plain      <= i_cfg_data;
                    default: ;
                endcase
            end

            // Drop the word once taken; S_OUT reloads it itself
            if (m_axis_tready && r_state != S_OUT) begin
                r_m_valid <= 1'b0;
            end

            // Compare stage of the scan, one read word behind the address
            r_cmp_vld <= (r_state == S_SCAN);
            r_cmp_idx <= r_scan_addr;
            r_rd_vld  <= r_bvalid[r_scan_addr];
            if (r_cmp_vld) begin
                if (r_cmp_idx == '0 || w_cand < r_best_val) begin
                    r_best     <= r_cmp_idx;
                    r_best_val <= w_cand;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func         <= s_axis_tuser[0];
                        r_chunk        <= s_axis_tdata[15:0];
                        r_column       <= s_axis_tdata[27:16];
                        r_job.cbytes   <= s_axis_tdata[59:28];
                        r_job.values   <= s_axis_tdata[91:60];
                        r_job.vsize    <= s_axis_tdata[96:92];
                        r_job.compressed <= s_axis_tdata[97];
                        r_id           <= '0;
                        r_scan_addr    <= '0;
                        if (s_axis_tuser[0] == FUNC_SCHEDULE) begin
                            r_refused <= w_full;
                            r_empty   <= 1'b0;
                            // Full queue: skip the scan, still report the estimate
                            r_state   <= w_full ? S_WAIT : S_SCAN;
                        end else begin
                            r_refused <= 1'b0;
                            r_empty   <= (r_count == '0);
                            r_state   <= (r_count == '0) ? S_OUT : S_DEQ;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_scan_addr == ID_W'(NUM_DECODERS - 1)) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_scan_addr <= r_scan_addr + ID_W'(1);
                    end
                end
                S_WAIT: begin
                    // Last compare retires on this edge, so the winner is ready next
                    if (w_cost_done) begin
                        r_state <= r_refused ? S_OUT : S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_bvalid[r_best] <= 1'b1;
                    r_id             <= r_best;
                    r_tail  <= (r_tail == PTR_W'(ORDER_DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_OUT;
                end
                S_DEQ: begin
                    r_id    <= w_fifo_rdata;
                    r_head  <= (r_head == PTR_W'(ORDER_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
                    r_count <= r_count - CNT_W'(1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Hold the result until the output register is free
                    if (w_out_free) begin
                        r_m_valid   <= 1'b1;
                        r_m_kind    <= r_func;
                        r_m_refused <= r_refused;
                        r_m_empty   <= r_empty;
                        r_m_id      <= w_id_ext[ID_OUT_W-1:0];
                        if (r_func == FUNC_SCHEDULE) begin
                            r_m_chunk  <= r_chunk;
                            r_m_column <= r_column;
                            r_m_cost   <= w_cost;
                        end else begin
                            r_m_chunk  <= '0;
                            r_m_column <= '0;
                            r_m_cost   <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_cost, r_m_column, r_m_chunk, r_m_id};
    assign m_axis_tuser  = {r_m_empty, r_m_refused, r_m_kind};

    `LLDD_ASSERT_NEXT(a_push_count, r_state == S_UPDATE, r_count == $past(r_count) + CNT_W'(1), "push did not advance count")
    `LLDD_ASSERT_NEXT(a_pop_count, r_state == S_DEQ, r_count == $past(r_count) - CNT_W'(1), "pop did not drop count")
    `LLDD_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(ORDER_DEPTH), "order count beyond depth")
    `LLDD_ASSERT_SAME(a_push_room, r_state == S_UPDATE, !r_refused && r_count < CNT_W'(ORDER_DEPTH), "push into full queue")
    `LLDD_ASSERT_NEXT(a_out_load, r_state == S_OUT && w_out_free, r_m_valid && r_state == S_IDLE, "result not loaded")

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import lldd_pkg::*;

    localparam int N_DECODERS  = 16;
    localparam int ORDER_SLOTS = 64;
    // Index outside the register map; the block must ignore a write to it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd200;
    localparam logic [RATE_W-1:0]    RATE_MAX     = '1;

    // One job word as the sender sees it.
    typedef struct packed {
        logic                func;
        logic [CHUNK_W-1:0]  chunk;
        logic [COLUMN_W-1:0] column;
        logic [BYTES_W-1:0]  cbytes;
        logic [VALUES_W-1:0] values;
        logic [VSIZE_W-1:0]  vsize;
        logic                compressed;
    } t_job_word;

    // One dispatch answer as the block should return it.
    typedef struct packed {
        logic                kind;
        logic [ID_OUT_W-1:0] id;
        logic [CHUNK_W-1:0]  chunk;
        logic [COLUMN_W-1:0] column;
        logic [TIME_W-1:0]   cost;
        logic                refused;
        logic                empty;
    } t_answer;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // chunk_index, column_index, compressed_bytes, value_count, value_size,
    // is_compressed, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // func
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // decoder number, job_chunk, job_column, job_cost
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // result_kind, refused, order_empty
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [RATE_W-1:0]     i_cfg_data = '0;

    least_loaded_decoder_dispatch #(
        .NUM_DECODERS (N_DECODERS),
        .ORDER_DEPTH  (ORDER_SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idle probabilities in percent per cycle, changed between phases.
    int unsigned tx_idle_pct = 7;
    int unsigned rx_idle_pct = 53;

    int unsigned mismatch_count = 0;

    // Answers predicted for accepted words, oldest first.
    t_answer awaited_answers[$];

    // Shadow of the cost registers and of the dispatch state.
    logic [RATE_W-1:0] cost_setup;
    logic [RATE_W-1:0] cost_transfer;
    logic [RATE_W-1:0] cost_decompress;
    logic [RATE_W-1:0] cost_plain;
    logic [TIME_W-1:0] busy_until [N_DECODERS];
    logic [ID_OUT_W-1:0] order_ids [ORDER_SLOTS];
    int unsigned order_head;
    int unsigned order_count;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] sat_mul64(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return (|p[127:64]) ? '1 : p[63:0];
    endfunction

    // Estimate the job cost and apply the greedy pick to the shadow state, or pop the shadow queue.
    function automatic t_answer dispatch_predict(input t_job_word w);
        t_answer     a;
        logic [63:0] out_bytes;
        logic [63:0] cost;
        int          best;
        a = '0;
        a.kind = w.func;
        if (w.func == FUNC_SCHEDULE) begin
            out_bytes = 64'(w.values) * 64'(w.vsize);
            cost = 64'(cost_setup);
            cost = sat_add64(cost, sat_mul64(64'(cost_transfer), 64'(w.cbytes) + out_bytes));
            if (w.compressed)
                cost = sat_add64(cost, sat_mul64(64'(cost_decompress), 64'(w.cbytes)));
            cost = sat_add64(cost, sat_mul64(64'(cost_plain), 64'(w.values)));
            a.cost   = cost;
            a.chunk  = w.chunk;
            a.column = w.column;
            if (order_count >= ORDER_SLOTS) begin
                a.refused = 1'b1;
            end else begin
                best = 0;
                for (int d = 1; d < N_DECODERS; d++) begin
                    if (busy_until[d] < busy_until[best])
                        best = d;
                end
                busy_until[best] = sat_add64(busy_until[best], cost);
                order_ids[(order_head + order_count) % ORDER_SLOTS] = best[ID_OUT_W-1:0];
                order_count++;
                a.id = best[ID_OUT_W-1:0];
            end
        end else begin
            if (order_count == 0) begin
                a.empty = 1'b1;
            end else begin
                a.id = order_ids[order_head];
                order_head = (order_head + 1) % ORDER_SLOTS;
                order_count--;
            end
        end
        return a;
    endfunction

    function automatic t_job_word make_job(input logic func, input logic [15:0] chunk,
                                           input logic [11:0] column, input logic [31:0] cbytes,
                                           input logic [31:0] values, input logic [4:0] vsize,
                                           input logic compressed);
        t_job_word w;
        w.func       = func;
        w.chunk      = chunk;
        w.column     = column;
        w.cbytes     = cbytes;
        w.values     = values;
        w.vsize      = vsize;
        w.compressed = compressed;
        return w;
    endfunction

    // Favour the corners and small ranges of a count field, otherwise draw it uniformly.
    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return '1;
            2: return 32'($urandom_range(0, 255));
            3: return 32'($urandom_range(0, 1 << 20));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_job_word random_job(input int unsigned sched_pct);
        t_job_word w;
        w.func       = ($urandom_range(0, 99) < sched_pct) ? FUNC_SCHEDULE : FUNC_DEQUEUE;
        w.chunk      = 16'($urandom);
        w.column     = 12'($urandom);
        w.cbytes     = pick_count();
        w.values     = pick_count();
        // Mostly legal value sizes, now and then 0 or above 16.
        w.vsize      = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
        w.compressed = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic logic [RATE_W-1:0] random_rate();
        case ($urandom_range(0, 3))
            0: return 40'($urandom_range(0, 1 << 24));
            1: return {8'($urandom), $urandom};
            default: return 40'({$urandom} & 32'h3FFF_FFFF);
        endcase
    endfunction

    // Present one job word, idling at random first; hold valid through stalls.
    task automatic send_job(input t_job_word w);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {6'd0, w.compressed, w.vsize, w.values, w.cbytes, w.column, w.chunk};
        s_axis_tuser  <= w.func;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        awaited_answers.insert(awaited_answers.size(), dispatch_predict(w));
    endtask

    // Drop valid and hold until every predicted answer has been seen.
    task automatic drain_answers();
        s_axis_tvalid <= 1'b0;
        while (awaited_answers.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cost_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_SETUP:      cost_setup      = data;
            CFG_TRANSFER:   cost_transfer   = data;
            CFG_DECOMPRESS: cost_decompress = data;
            CFG_PLAIN:      cost_plain      = data;
            default: ;
        endcase
    endtask

    task automatic load_costs(input logic [RATE_W-1:0] setup, input logic [RATE_W-1:0] transfer,
                              input logic [RATE_W-1:0] decompress,
                              input logic [RATE_W-1:0] plain);
        drain_answers();
        write_cost_reg(CFG_SETUP, setup);
        write_cost_reg(CFG_TRANSFER, transfer);
        write_cost_reg(CFG_DECOMPRESS, decompress);
        write_cost_reg(CFG_PLAIN, plain);
    endtask

    // Corner words at the default costs: empty dequeue, zero and full-scale
    // jobs, value sizes 0, 1, 16, 17 and 31, ties among idle decoders.
    task automatic test_directed_jobs();
        send_job(make_job(FUNC_DEQUEUE, 16'hFFFF, 12'hFFF, '1, '1, 5'd31, 1'b1));
        send_job(make_job(FUNC_SCHEDULE, 16'd0, 12'd0, 32'd0, 32'd0, 5'd0, 1'b0));
        send_job(make_job(FUNC_SCHEDULE, 16'hFFFF, 12'hFFF, '1, '1, 5'd31, 1'b1));
        send_job(make_job(FUNC_SCHEDULE, 16'h1234, 12'h0AB, 32'd1000, 32'd250, 5'd1, 1'b0));
        send_job(make_job(FUNC_SCHEDULE, 16'h8001, 12'h800, 32'd65536, 32'd8192, 5'd16, 1'b1));
        send_job(make_job(FUNC_SCHEDULE, 16'h00FF, 12'h001, 32'd4096, 32'd512, 5'd17, 1'b0));
        send_job(make_job(FUNC_SCHEDULE, 16'd0, 12'd0, 32'd0, 32'd0, 5'd0, 1'b0));
        send_job(make_job(FUNC_SCHEDULE, 16'h5555, 12'hAAA, '1, 32'd0, 5'd8, 1'b1));
        send_job(make_job(FUNC_SCHEDULE, 16'hAAAA, 12'h555, 32'd0, '1, 5'd4, 1'b0));
        repeat (9)
            send_job(make_job(FUNC_DEQUEUE, 16'd0, 12'd0, 32'd0, 32'd0, 5'd1, 1'b0));
    endtask

    // Overfill the order queue so schedules are refused, then drain it past empty.
    task automatic test_order_fill_drain();
        repeat (ORDER_SLOTS + 6)
            send_job(random_job(100));
        repeat (ORDER_SLOTS + 6)
            send_job(random_job(0));
    endtask

    // Runs of schedule-heavy, dequeue-heavy and mixed traffic.
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned left;
        int unsigned run_len;
        int unsigned sched_pct;
        left = n_items;
        while (left > 0) begin
            run_len = $urandom_range(8, 60);
            if (run_len > left)
                run_len = left;
            case ($urandom_range(0, 2))
                0: sched_pct = 88;
                1: sched_pct = 15;
                default: sched_pct = 50;
            endcase
            repeat (run_len)
                send_job(random_job(sched_pct));
            left -= run_len;
        end
    endtask

    // Receiver: stall at random, independently of the sender.
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each accepted answer with the oldest prediction.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (awaited_answers.size() == 0) begin
                $error("unexpected answer word: tdata %h tuser %h", m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                want = awaited_answers[0];
                awaited_answers.delete(0);
                check_field("result_kind", 64'(want.kind), 64'(m_axis_tuser[0]));
                check_field("chosen_decoder", 64'(want.id), 64'(m_axis_tdata[3:0]));
                check_field("job_chunk", 64'(want.chunk), 64'(m_axis_tdata[19:4]));
                check_field("job_column", 64'(want.column), 64'(m_axis_tdata[31:20]));
                check_field("job_cost", want.cost, m_axis_tdata[95:32]);
                check_field("refused", 64'(want.refused), 64'(m_axis_tuser[1]));
                check_field("order_empty", 64'(want.empty), 64'(m_axis_tuser[2]));
            end
        end
    end

    initial begin
        cost_setup      = SETUP_RST;
        cost_transfer   = TRANSFER_RST;
        cost_decompress = DECOMPRESS_RST;
        cost_plain      = PLAIN_RST;
        foreach (busy_until[d])
            busy_until[d] = '0;
        foreach (order_ids[k])
            order_ids[k] = '0;
        order_head  = 0;
        order_count = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase one: sender rarely idles, receiver stalls about half the time.
        tx_idle_pct = 7;
        rx_idle_pct = 53;
        test_directed_jobs();
        load_costs(RATE_MAX, RATE_MAX, RATE_MAX, RATE_MAX);
        write_cost_reg(CFG_UNMAPPED, random_rate());
        test_random_traffic(150);
        load_costs('0, '0, '0, '0);
        test_random_traffic(120);
        load_costs(random_rate(), random_rate(), random_rate(), random_rate());
        test_order_fill_drain();

        // Phase two: swap the idle rates.
        drain_answers();
        tx_idle_pct = 53;
        rx_idle_pct = 7;
        load_costs('0, RATE_MAX, '0, RATE_MAX);
        test_random_traffic(200);
        load_costs(random_rate(), random_rate(), random_rate(), random_rate());
        test_random_traffic(250);

        // Phase three: no idling on either side.
        drain_answers();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_costs(SETUP_RST, TRANSFER_RST, DECOMPRESS_RST, PLAIN_RST);
        test_random_traffic(250);
        load_costs(RATE_MAX, random_rate(), '0, random_rate());
        test_order_fill_drain();
        test_random_traffic(180);

        // Wait out the schedule latency for any stray word.
        drain_answers();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/lldd_pkg.sv
design/lldd_ram.sv
design/lldd_cost.sv
design/least_loaded_decoder_dispatch.sv
tb/sv/tb.sv
